### hw/rtl/tfrq_pkg.sv
// Shared types and codes for the TLV frame receiver queue.
// No dependencies; used by every module of the block.
`default_nettype none
package tfrq_pkg;

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_LEN0 = 3'd1,
      PH_LEN1 = 3'd2,
      PH_LEN2 = 3'd3,
      PH_LEN3 = 3'd4,
      PH_DATA = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PROGRESS = 3'd1,
      EV_STORED   = 3'd2,
      EV_DROPPED  = 3'd3,
      EV_BADCMD   = 3'd4,
      EV_OVERSIZE = 3'd5
   } event_type;

   typedef enum logic {
      ENG_IDLE  = 1'b0,
      ENG_RDATA = 1'b1
   } eng_state_type;

   typedef enum logic [1:0] {
      CSR_CODE_A  = 2'd0,
      CSR_CODE_B  = 2'd1,
      CSR_TIMEOUT = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   localparam logic OP_FEED = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [7:0]  code_a;
      logic [7:0]  code_b;
      logic [15:0] timeout;
   } cfg_type;

endpackage
`default_nettype wire

### hw/rtl/tfrq_in_fifo.sv
// Front queue: two-word buffer between the input port and the engine.
// Depends on tfrq_pkg.
`default_nettype none
module tfrq_in_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  tfrq_pkg::item_type  push_item,
   output logic                item_valid,
   output tfrq_pkg::item_type  item,
   input  wire                 item_pop
);
   tfrq_pkg::item_type buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = buf_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/tfrq_engine.sv
// Back part: frame parser, slot ring with payload memory, and result register.
// Depends on tfrq_pkg.
`default_nettype none
module tfrq_engine #(
   parameter int MAX_PAYLOAD = 192,
   parameter int FRAME_SLOTS = 8,
   parameter int QW          = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  tfrq_pkg::cfg_type   cfg,
   input  wire                 item_valid,
   input  tfrq_pkg::item_type  item,
   output logic                item_pop,
   input  wire                 rsp_pop,
   output logic                rsp_valid,
   output logic                rsp_gap_abort,
   output logic [2:0]          rsp_rx_event,
   output logic                rsp_read_valid,
   output logic [7:0]          rsp_frame_command,
   output logic [7:0]          rsp_frame_length,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_last_of_frame,
   output logic [QW-1:0]       rsp_frames_queued
);
   localparam int PHYS = FRAME_SLOTS + 1;
   localparam int SW   = $clog2(PHYS);
   localparam int AW   = $clog2(PHYS * MAX_PAYLOAD);
   localparam int MW   = PHYS * MAX_PAYLOAD;

   tfrq_pkg::eng_state_type state_ff, state_in;
   tfrq_pkg::phase_type     phase_ff, phase_in, eff_phase;
   logic [7:0]    cmd_ff, cmd_in;
   logic [31:0]   len_ff, len_in, len_full;
   logic [7:0]    idx_ff, idx_in;
   logic [31:0]   last_time_ff, last_time_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QW-1:0] count_ff, count_in;
   logic [7:0]    off_ff, off_in;

   logic [7:0]    pay_mem [MW];
   logic [7:0]    mem_q_ff;
   logic [7:0]    slot_cmd_ff [PHYS];
   logic [7:0]    slot_len_ff [PHYS];

   logic          out_free, is_feed, rd_start, rsp_load;
   logic          abort;
   logic [31:0]   gap;
   tfrq_pkg::event_type ev;
   logic          mem_we, store_req, store_ok;
   logic [7:0]    store_len;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_len;
   logic          rd_last;
   logic [8:0]    idx_next, off_next;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          o_abort_ff, o_rv_ff, o_last_ff;
   logic [2:0]    o_ev_ff;
   logic [7:0]    o_cmd_ff, o_len_ff, o_pb_ff;
   logic [QW-1:0] o_q_ff;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign is_feed  = (item.opcode == tfrq_pkg::OP_FEED);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tfrq_pkg::ENG_IDLE:  if (rd_start) state_in = tfrq_pkg::ENG_RDATA;
         tfrq_pkg::ENG_RDATA: if (out_free) state_in = tfrq_pkg::ENG_IDLE;
         default:             state_in = tfrq_pkg::ENG_IDLE;
      endcase
   end

   always_comb begin
      item_pop = 1'b0;
      rd_start = 1'b0;
      unique case (state_ff)
         tfrq_pkg::ENG_IDLE: begin
            if (item_valid && out_free) begin
               if (is_feed || count_ff == '0) begin
                  item_pop = 1'b1;
               end else begin
                  rd_start = 1'b1;
               end
            end
         end
         tfrq_pkg::ENG_RDATA: item_pop = out_free;
         default: item_pop = 1'b0;
      endcase
   end

   assign rsp_load = item_pop;

   // parse one received byte
   always_comb begin
      gap       = item.now_ms - last_time_ff;
      abort     = (phase_ff != tfrq_pkg::PH_CMD) && (gap > {16'd0, cfg.timeout});
      eff_phase = abort ? tfrq_pkg::PH_CMD : phase_ff;
      len_full  = {len_ff[31:8], item.rx_byte};
      idx_next  = {1'b0, idx_ff} + 9'd1;
      phase_in  = eff_phase;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      ev        = tfrq_pkg::EV_PROGRESS;
      mem_we    = 1'b0;
      store_req = 1'b0;
      store_len = len_ff[7:0];
      unique case (eff_phase)
         tfrq_pkg::PH_LEN0: begin
            len_in   = {item.rx_byte, 24'd0};
            phase_in = tfrq_pkg::PH_LEN1;
         end
         tfrq_pkg::PH_LEN1: begin
            len_in   = {len_ff[31:24], item.rx_byte, 16'd0};
            phase_in = tfrq_pkg::PH_LEN2;
         end
         tfrq_pkg::PH_LEN2: begin
            len_in   = {len_ff[31:16], item.rx_byte, 8'd0};
            phase_in = tfrq_pkg::PH_LEN3;
         end
         tfrq_pkg::PH_LEN3: begin
            len_in = len_full;
            idx_in = 8'd0;
            if (len_full > 32'(MAX_PAYLOAD)) begin
               ev       = tfrq_pkg::EV_OVERSIZE;
               phase_in = tfrq_pkg::PH_CMD;
            end else if (len_full == 32'd0) begin
               store_req = 1'b1;
               store_len = 8'd0;
               phase_in  = tfrq_pkg::PH_CMD;
            end else begin
               phase_in = tfrq_pkg::PH_DATA;
            end
         end
         tfrq_pkg::PH_DATA: begin
            mem_we = 1'b1;
            idx_in = idx_next[7:0];
            if (idx_next >= {1'b0, len_ff[7:0]}) begin
               store_req = 1'b1;
               phase_in  = tfrq_pkg::PH_CMD;
            end
         end
         default: begin
            if (item.rx_byte != cfg.code_a && item.rx_byte != cfg.code_b) begin
               ev       = tfrq_pkg::EV_BADCMD;
               phase_in = tfrq_pkg::PH_CMD;
            end else begin
               cmd_in   = item.rx_byte;
               len_in   = 32'd0;
               idx_in   = 8'd0;
               phase_in = tfrq_pkg::PH_LEN0;
            end
         end
      endcase
      store_ok = store_req && (count_ff < QW'(FRAME_SLOTS));
      if (store_req) begin
         ev = store_ok ? tfrq_pkg::EV_STORED : tfrq_pkg::EV_DROPPED;
      end
   end

   // read side of the slot ring, and payload write address
   always_comb begin
      rd_len   = slot_len_ff[tail_ff];
      off_next = {1'b0, off_ff} + 9'd1;
      rd_last  = (rd_len == 8'd0) || (off_next >= {1'b0, rd_len});
      rd_addr  = AW'(tail_ff) * AW'(MAX_PAYLOAD) + AW'(off_ff);
      wr_addr  = AW'(head_ff) * AW'(MAX_PAYLOAD) + AW'(idx_ff);
   end

   always_comb begin
      last_time_in = last_time_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      if (state_ff == tfrq_pkg::ENG_IDLE && item_pop && is_feed) begin
         last_time_in = item.now_ms;
         if (store_ok) begin
            head_in  = (head_ff == SW'(FRAME_SLOTS)) ? '0 : head_ff + SW'(1);
            count_in = count_ff + QW'(1);
         end
      end else if (state_ff == tfrq_pkg::ENG_RDATA && out_free) begin
         if (rd_last) begin
            off_in   = 8'd0;
            tail_in  = (tail_ff == SW'(FRAME_SLOTS)) ? '0 : tail_ff + SW'(1);
            count_in = count_ff - QW'(1);
         end else begin
            off_in = off_next[7:0];
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfrq_pkg::ENG_IDLE;
         phase_ff     <= tfrq_pkg::PH_CMD;
         cmd_ff       <= 8'd0;
         len_ff       <= 32'd0;
         idx_ff       <= 8'd0;
         last_time_ff <= 32'd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         off_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (state_ff == tfrq_pkg::ENG_IDLE && item_pop && is_feed) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            len_ff   <= len_in;
            idx_ff   <= idx_in;
         end
         last_time_ff <= last_time_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tfrq_pkg::ENG_IDLE && item_pop && is_feed && mem_we) begin
         pay_mem[wr_addr] <= item.rx_byte;
      end
      if (rd_start) begin
         mem_q_ff <= pay_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tfrq_pkg::ENG_IDLE && item_pop && is_feed && store_ok) begin
         slot_cmd_ff[head_ff] <= cmd_ff;
         slot_len_ff[head_ff] <= store_len;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         o_q_ff <= count_in;
         if (state_ff == tfrq_pkg::ENG_RDATA) begin
            o_abort_ff <= 1'b0;
            o_ev_ff    <= tfrq_pkg::EV_NONE;
            o_rv_ff    <= 1'b1;
            o_cmd_ff   <= slot_cmd_ff[tail_ff];
            o_len_ff   <= rd_len;
            o_pb_ff    <= (rd_len == 8'd0) ? 8'd0 : mem_q_ff;
            o_last_ff  <= rd_last;
         end else begin
            o_abort_ff <= is_feed && abort;
            o_ev_ff    <= is_feed ? ev : tfrq_pkg::EV_NONE;
            o_rv_ff    <= 1'b0;
            o_cmd_ff   <= 8'd0;
            o_len_ff   <= 8'd0;
            o_pb_ff    <= 8'd0;
            o_last_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gap_abort     = o_abort_ff;
   assign rsp_rx_event      = o_ev_ff;
   assign rsp_read_valid    = o_rv_ff;
   assign rsp_frame_command = o_cmd_ff;
   assign rsp_frame_length  = o_len_ff;
   assign rsp_payload_byte  = o_pb_ff;
   assign rsp_last_of_frame = o_last_ff;
   assign rsp_frames_queued = o_q_ff;
endmodule
`default_nettype wire

### hw/rtl/tlv_frame_receiver_queue.sv
// Top level: TLV frame receiver with frame queue, config registers, assertions.
// Depends on tfrq_pkg, tfrq_in_fifo, tfrq_engine.
//
//   channel  handshake              payload
//   req      push / full            req_opcode, req_rx_byte, req_now_ms
//   rsp      pop / empty            rsp_gap_abort .. rsp_frames_queued
//   csr      csr_valid / csr_ready  csr_index, csr_wdata
//
// A frame read passes the engine through states IDLE and RDATA (payload memory
// read port is registered); a received byte or a read of an empty queue stays in IDLE.
// Two-word input queue and one-word result register decouple both sides.
// Reset is synchronous; no memory clearing pass, slots are read only after written.
// The engine stalls while the result register is full and not popped.
`default_nettype none
module tlv_frame_receiver_queue #(
   parameter int MAX_PAYLOAD = 192,
   parameter int FRAME_SLOTS = 8,
   parameter int QW          = $clog2(FRAME_SLOTS + 1)
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           push,
   output logic          full,
   input  wire           req_opcode,
   input  wire  [7:0]    req_rx_byte,
   input  wire  [31:0]   req_now_ms,
   output logic          empty,
   input  wire           pop,
   output logic          rsp_gap_abort,
   output logic [2:0]    rsp_rx_event,
   output logic          rsp_read_valid,
   output logic [7:0]    rsp_frame_command,
   output logic [7:0]    rsp_frame_length,
   output logic [7:0]    rsp_payload_byte,
   output logic          rsp_last_of_frame,
   output logic [QW-1:0] rsp_frames_queued,
   input  wire           csr_valid,
   output logic          csr_ready,
   input  wire  [1:0]    csr_index,
   input  wire  [15:0]   csr_wdata
);
   tfrq_pkg::cfg_type  cfg_ff, cfg_in;
   tfrq_pkg::item_type push_item, item;
   logic item_valid, item_pop, rsp_valid;

   assign csr_ready = 1'b1;
   assign push_item = '{opcode: req_opcode, rx_byte: req_rx_byte, now_ms: req_now_ms};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (tfrq_pkg::csr_index_type'(csr_index))
            tfrq_pkg::CSR_CODE_A:  cfg_in.code_a  = csr_wdata[7:0];
            tfrq_pkg::CSR_CODE_B:  cfg_in.code_b  = csr_wdata[7:0];
            tfrq_pkg::CSR_TIMEOUT: cfg_in.timeout = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{code_a: 8'd4, code_b: 8'd5, timeout: 16'd100};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfrq_in_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .push_item  (push_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   tfrq_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .FRAME_SLOTS (FRAME_SLOTS),
      .QW          (QW)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop),
      .rsp_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_gap_abort     (rsp_gap_abort),
      .rsp_rx_event      (rsp_rx_event),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frames_queued (rsp_frames_queued)
   );

   assign empty = !rsp_valid;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_frames_queued <= QW'(FRAME_SLOTS)))
      else $error("frames_queued beyond slot count");

   a_last_needs_read: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_frame) |-> rsp_read_valid)
      else $error("last_of_frame without read_valid");

   a_read_no_event: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_read_valid) |-> (rsp_rx_event == 3'(tfrq_pkg::EV_NONE) && !rsp_gap_abort))
      else $error("read result carries receive event");
endmodule
`default_nettype wire

### dv/tlv_frame_receiver_queue_tb.sv
// Self-checking testbench for tlv_frame_receiver_queue: drives received bytes and reads,
// predicts every result word in a behavioral model of the frame receiver and queue.
// Depends on tfrq_pkg and the tlv_frame_receiver_queue RTL.
`default_nettype none
module tlv_frame_receiver_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfrq_pkg::*;

   localparam int MAXP = 192;
   localparam int SLOTS = 8;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic       gap_abort;
      logic [2:0] rx_event;
      logic       read_valid;
      logic [7:0] frame_command;
      logic [7:0] frame_length;
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic [3:0] frames_queued;
   } frame_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_opcode = 1'b0;
   logic [7:0] req_rx_byte = '0;
   logic [31:0] req_now_ms = '0;
   logic empty;
   logic pop = 1'b0;
   logic rsp_gap_abort;
   logic [2:0] rsp_rx_event;
   logic rsp_read_valid;
   logic [7:0] rsp_frame_command;
   logic [7:0] rsp_frame_length;
   logic [7:0] rsp_payload_byte;
   logic rsp_last_of_frame;
   logic [3:0] rsp_frames_queued;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   tlv_frame_receiver_queue uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_rx_byte(req_rx_byte), .req_now_ms(req_now_ms),
      .empty(empty), .pop(pop), .rsp_gap_abort(rsp_gap_abort),
      .rsp_rx_event(rsp_rx_event), .rsp_read_valid(rsp_read_valid),
      .rsp_frame_command(rsp_frame_command), .rsp_frame_length(rsp_frame_length),
      .rsp_payload_byte(rsp_payload_byte), .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_frames_queued(rsp_frames_queued), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0] code_a, code_b;
   logic [15:0] gap_limit;
   phase_type rx_ph;
   logic [7:0] rx_cmd;
   logic [31:0] rx_len, last_stamp;
   int rx_idx;
   logic [7:0] asm_buf [MAXP];
   logic [7:0] slot_data [SLOTS][MAXP];
   logic [7:0] slot_cmd [SLOTS];
   logic [7:0] slot_len [SLOTS];
   int q_head, q_tail, q_count, rd_off;

   item_type pending_words[$];
   frame_rsp_t expected_words[$];
   int mismatches = 0;
   int stall_cycles = 0;
   bit timed_out = 0;
   bit sender_hold = 0;
   logic [31:0] clock_ms = 0;

   function automatic event_type store_frame();
      if (q_count >= SLOTS) return EV_DROPPED;
      slot_cmd[q_head] = rx_cmd;
      slot_len[q_head] = rx_len[7:0];
      for (int i = 0; i < rx_len; i++) slot_data[q_head][i] = asm_buf[i];
      q_head = (q_head + 1) % SLOTS;
      q_count++;
      return EV_STORED;
   endfunction

   function automatic void rx_idle();
      rx_ph = PH_CMD;
      rx_cmd = '0;
      rx_len = '0;
      rx_idx = 0;
   endfunction

   function automatic frame_rsp_t predict_word(item_type it);
      frame_rsp_t r;
      logic [7:0] b;
      r = '0;
      b = it.rx_byte;
      if (it.opcode == OP_FEED) begin
         if (rx_ph != PH_CMD && (it.now_ms - last_stamp) > {16'd0, gap_limit}) begin
            r.gap_abort = 1'b1;
            rx_idle();
         end
         last_stamp = it.now_ms;
         r.rx_event = EV_PROGRESS;
         case (rx_ph)
            PH_LEN0: begin rx_len = {b, 24'd0}; rx_ph = PH_LEN1; end
            PH_LEN1: begin rx_len[23:16] = b; rx_ph = PH_LEN2; end
            PH_LEN2: begin rx_len[15:8] = b; rx_ph = PH_LEN3; end
            PH_LEN3: begin
               rx_len[7:0] = b;
               if (rx_len > MAXP) begin
                  r.rx_event = EV_OVERSIZE;
                  rx_idle();
               end else if (rx_len == 0) begin
                  r.rx_event = store_frame();
                  rx_idle();
               end else begin
                  rx_idx = 0;
                  rx_ph = PH_DATA;
               end
            end
            PH_DATA: begin
               if (rx_idx < MAXP) begin
                  asm_buf[rx_idx] = b;
                  rx_idx++;
               end
               if (rx_idx >= rx_len) begin
                  r.rx_event = store_frame();
                  rx_idle();
               end
            end
            default: begin
               if (b != code_a && b != code_b) begin
                  r.rx_event = EV_BADCMD;
                  rx_idle();
               end else begin
                  rx_cmd = b;
                  rx_len = '0;
                  rx_idx = 0;
                  rx_ph = PH_LEN0;
               end
            end
         endcase
      end else if (q_count > 0) begin
         r.read_valid = 1'b1;
         r.frame_command = slot_cmd[q_tail];
         r.frame_length = slot_len[q_tail];
         if (slot_len[q_tail] > 0 && rd_off < slot_len[q_tail])
            r.payload_byte = slot_data[q_tail][rd_off];
         if (slot_len[q_tail] == 0 || rd_off + 1 >= slot_len[q_tail]) begin
            r.last_of_frame = 1'b1;
            rd_off = 0;
            q_tail = (q_tail + 1) % SLOTS;
            q_count--;
         end else begin
            rd_off++;
         end
      end
      r.frames_queued = q_count[3:0];
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // stimulus builders; time advances by a small step within a frame
   function automatic void add_word(logic op, logic [7:0] b, int dt);
      item_type it;
      clock_ms = clock_ms + dt;
      it.opcode = op;
      it.rx_byte = b;
      it.now_ms = (op == OP_FEED) ? clock_ms : $urandom;
      pending_words.push_back(it);
   endfunction

   function automatic void add_frame(logic [7:0] cmd, logic [31:0] len, int cut);
      add_word(OP_FEED, cmd, $urandom_range(0, 20));
      for (int k = 3; k >= 0; k--) add_word(OP_FEED, len[8*k +: 8], $urandom_range(0, 20));
      for (int i = 0; i < len && i < cut; i++) add_word(OP_FEED, $urandom, $urandom_range(0, 20));
   endfunction

   function automatic void add_reads(int n);
      for (int i = 0; i < n; i++) add_word(OP_READ, $urandom, 0);
   endfunction

   // driver
   int send_gap = 0;
   bit took = 0;
   always @(negedge clock) begin
      bit was_taken;
      if (!reset) begin
         was_taken = took;
         took = 0;
         if (was_taken) begin
            if (pending_words.size() > 0) void'(pending_words.pop_front());
            send_gap = gap_len();
         end
         if (was_taken || !push) begin
            if (send_gap > 0 || sender_hold || pending_words.size() == 0) begin
               if (send_gap > 0) send_gap--;
               push <= 1'b0;
            end else begin
               push <= 1'b1;
               req_opcode <= pending_words[0].opcode;
               req_rx_byte <= pending_words[0].rx_byte;
               req_now_ms <= pending_words[0].now_ms;
            end
         end
      end
   end

   // accept into predictor at the rising edge
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         expected_words.push_back(predict_word({req_opcode, req_rx_byte, req_now_ms}));
         took = 1;
      end
   end

   // receiver stall
   int pop_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            pop_gap = gap_len();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_rsp_t got, want;
      if (!reset && pop && !empty) begin
         got = {rsp_gap_abort, rsp_rx_event, rsp_read_valid, rsp_frame_command,
                rsp_frame_length, rsp_payload_byte, rsp_last_of_frame, rsp_frames_queued};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("[tlv_frame_receiver_queue] ERROR");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CODE_A: code_a = val[7:0];
         CSR_CODE_B: code_b = val[7:0];
         CSR_TIMEOUT: gap_limit = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_words.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int p;
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         c = $urandom_range(0, 1) ? code_a : code_b;
         if (p < 45) begin
            if ($urandom_range(0, 9) == 0)
               add_frame(c, $urandom_range(150, MAXP), 1000);
            else
               add_frame(c, $urandom_range(0, 12), 1000);
            add_reads($urandom_range(0, 14));
         end else if (p < 55) begin
            add_frame(c, $urandom_range(1, 10), $urandom_range(0, 4));
            clock_ms = clock_ms + $urandom_range(0, 1) * (gap_limit + $urandom_range(1, 300));
         end else if (p < 62) begin
            add_frame(c, $urandom, 0);
         end else if (p < 70) begin
            add_frame(c, {24'd0, 8'd193} + $urandom_range(0, 62), 0);
         end else if (p < 80) begin
            add_word(OP_FEED, $urandom, $urandom_range(0, 400));
         end else begin
            add_reads($urandom_range(1, 8));
         end
      end
   endtask

   initial begin
      code_a = 8'd4;
      code_b = 8'd5;
      gap_limit = 16'd100;
      rx_idle();
      last_stamp = '0;
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      rd_off = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads of empty queue, bad command, max and empty frames,
      // oversize, timeout abort, idle gap, queue overflow, full readout
      add_reads(2);
      add_word(OP_FEED, 8'hFF, 1);
      add_frame(8'd4, 0, 1000);
      add_frame(8'd5, MAXP, 1000);
      add_frame(8'd4, 32'hFFFF_FFFF, 0);
      add_frame(8'd5, 32'd193, 0);
      add_frame(8'd4, 3, 1);
      clock_ms = clock_ms + 101;
      add_word(OP_FEED, 8'd4, 0);
      add_word(OP_FEED, 8'd0, 100);
      add_reads(1);
      drain();

      for (int i = 0; i < 9; i++) add_frame(8'd4, 1, 1000);
      add_reads(14);
      drain();
      add_reads(MAXP + 2);
      drain();

      csr_write(CSR_CODE_A, 16'h00FF);
      csr_write(CSR_CODE_B, 16'h0000);
      csr_write(CSR_TIMEOUT, 16'd0);
      random_phase(12);
      repeat (100) @(posedge clock);
      sender_hold = 1;
      while (expected_words.size() > 0) @(posedge clock);
      sender_hold = 0;
      add_reads(SLOTS * 16);
      drain();

      csr_write(CSR_CODE_A, 16'h00FF);
      csr_write(CSR_CODE_B, 16'h00FF);
      csr_write(CSR_TIMEOUT, 16'hFFFF);
      clock_ms = 32'hFFFF_FF00;
      random_phase(12);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         csr_write(CSR_CODE_A, $urandom_range(0, 255));
         csr_write(CSR_CODE_B, $urandom_range(0, 255));
         csr_write(CSR_TIMEOUT, $urandom_range(5, 60));
         random_phase(4);
         drain();
      end

      if (mismatches == 0)
         $display("[tlv_frame_receiver_queue] OK");
      else
         $display("[tlv_frame_receiver_queue] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/tfrq_pkg.sv
hw/rtl/tfrq_in_fifo.sv
hw/rtl/tfrq_engine.sv
hw/rtl/tlv_frame_receiver_queue.sv
dv/tlv_frame_receiver_queue_tb.sv
